// ===== src/sccb_pkg.sv =====
// Shared types, constants and register indexes for the SCCB register master.
package sccb_pkg;

    localparam int DELAY_WIDTH_DEF = 8;
    localparam int QDEPTH          = 2;
    localparam int CFG_IDX_W       = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEV   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLKLO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLKHI = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DHOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STOP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FREE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SETUP = 3'd7;

    // reset values of the timing registers
    localparam logic [7:0] RST_DEV   = 8'd0;
    localparam logic [7:0] RST_START = 8'd4;
    localparam logic [7:0] RST_CLKLO = 8'd5;
    localparam logic [7:0] RST_CLKHI = 8'd4;
    localparam logic [7:0] RST_DHOLD = 8'd1;
    localparam logic [7:0] RST_STOP  = 8'd4;
    localparam logic [7:0] RST_FREE  = 8'd5;
    localparam logic [7:0] RST_SETUP = 8'd1;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DEV_NAK = 2'd1;
    localparam logic [1:0] ST_REG_NAK = 2'd2;
    localparam logic [1:0] ST_DAT_NAK = 2'd3;

    typedef struct packed {
        logic       tick;
        logic       cmd_valid;
        logic       func;
        logic [7:0] reg_addr;
        logic [7:0] wr_data;
        logic       sda_in;
    } req_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] rd_data;
    } res_t;

    typedef struct packed {
        logic [7:0] device_address;
        logic [7:0] start_hold_ticks;
        logic [7:0] clock_low_ticks;
        logic [7:0] clock_high_ticks;
        logic [7:0] data_hold_ticks;
        logic [7:0] stop_hold_ticks;
        logic [7:0] bus_free_ticks;
        logic [7:0] low_setup_ticks;
    } cfg_t;

endpackage

// ===== src/sccb_register_master_top.sv =====
// Top level of the SCCB register master: config registers, front queue, bus sequencer.
//
// Usage notes
// - Request channel (item_valid / item_stall / item): one request per step of
//   the sequencer. Each request carries the time tick, an optional
//   command (write or read of one sensor register) and the sampled SDA level.
// - Result channel (result_valid / result_stall / result): exactly one result
//   per request, in order, giving SCL, SDA drive, busy, done, status, rd_data.
// - Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): eight 8-bit
//   registers, device address then seven phase timings. cfg_ready is always
//   high; write only while no requests are in flight.
// - A request goes into the queue, then its result into the output register.
//   Throughput: one request per cycle unless result_stall holds a valid result;
//   each request is a single step of the sequencer's phase counter.
// - A two-entry queue sits between the front end and the sequencer; item_stall
//   rises only when it is full, i.e. once result_stall has held the output
//   register long enough to back requests up.
// - Stalled results hold steady in the output register.
// - Reset: bus released (SCL high, SDA not driven), sequencer idle, status ok,
//   timing registers at their defaults, queue and output register empty.
module sccb_register_master_top #(
    parameter int DELAY_WIDTH = sccb_pkg::DELAY_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  sccb_pkg::req_t                  item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output sccb_pkg::res_t                  result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sccb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                      cfg_data
);
    import sccb_pkg::*;

    cfg_t cfg_reg;
    logic head_valid;
    req_t head;
    logic pop;

    // config writes are never held off
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address   <= RST_DEV;
            cfg_reg.start_hold_ticks <= RST_START;
            cfg_reg.clock_low_ticks  <= RST_CLKLO;
            cfg_reg.clock_high_ticks <= RST_CLKHI;
            cfg_reg.data_hold_ticks  <= RST_DHOLD;
            cfg_reg.stop_hold_ticks  <= RST_STOP;
            cfg_reg.bus_free_ticks   <= RST_FREE;
            cfg_reg.low_setup_ticks  <= RST_SETUP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DEV:   cfg_reg.device_address   <= cfg_data;
                REG_START: cfg_reg.start_hold_ticks <= cfg_data;
                REG_CLKLO: cfg_reg.clock_low_ticks  <= cfg_data;
                REG_CLKHI: cfg_reg.clock_high_ticks <= cfg_data;
                REG_DHOLD: cfg_reg.data_hold_ticks  <= cfg_data;
                REG_STOP:  cfg_reg.stop_hold_ticks  <= cfg_data;
                REG_FREE:  cfg_reg.bus_free_ticks   <= cfg_data;
                REG_SETUP: cfg_reg.low_setup_ticks  <= cfg_data;
                default:   cfg_reg.device_address   <= cfg_reg.device_address;
            endcase
        end
    end

    // front end: request queue
    sccb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // back end: bus sequencer and result register
    sccb_back #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== src/sccb_front.sv =====
// Front end: accepts requests and queues them for the bus sequencer.
module sccb_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  sccb_pkg::req_t  item,
    output logic            head_valid,
    output sccb_pkg::req_t  head,
    input  logic            pop
);
    import sccb_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;

    req_t             q_mem [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             do_pop;

    assign item_stall = (count_reg == CNT_W'(QDEPTH));
    assign push       = item_valid && !item_stall;
    assign head_valid = (count_reg != '0);
    assign head       = q_mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= item;
        end
    end

endmodule

// ===== src/sccb_back.sv =====
// Back end: SCCB bus sequencer, one step per request, with output register.
module sccb_back #(
    parameter int DELAY_WIDTH = sccb_pkg::DELAY_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  sccb_pkg::cfg_t  cfg,
    input  logic            head_valid,
    input  sccb_pkg::req_t  head,
    output logic            pop,
    output logic            result_valid,
    input  logic            result_stall,
    output sccb_pkg::res_t  result
);
    import sccb_pkg::*;

    localparam int CW = ((DELAY_WIDTH > 8) ? DELAY_WIDTH : 8) + 1;
    localparam logic [CW-1:0] DLY_MAX = CW'(1) << DELAY_WIDTH;

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_S_HOLD  = 4'd1;
    localparam logic [3:0] PH_S_LOW   = 4'd2;
    localparam logic [3:0] PH_W_HOLD  = 4'd3;
    localparam logic [3:0] PH_W_SETUP = 4'd4;
    localparam logic [3:0] PH_W_HIGH  = 4'd5;
    localparam logic [3:0] PH_A_LOW   = 4'd6;
    localparam logic [3:0] PH_A_HIGH  = 4'd7;
    localparam logic [3:0] PH_R_LOW   = 4'd8;
    localparam logic [3:0] PH_R_HIGH  = 4'd9;
    localparam logic [3:0] PH_N_HOLD  = 4'd10;
    localparam logic [3:0] PH_N_SETUP = 4'd11;
    localparam logic [3:0] PH_N_HIGH  = 4'd12;
    localparam logic [3:0] PH_P_SETUP = 4'd13;
    localparam logic [3:0] PH_P_HOLD  = 4'd14;
    localparam logic [3:0] PH_P_FREE  = 4'd15;

    // byte stage of the transaction
    localparam logic [2:0] SG_DEV_WR = 3'd0;
    localparam logic [2:0] SG_REG    = 3'd1;
    localparam logic [2:0] SG_DATA   = 3'd2;
    localparam logic [2:0] SG_DEV_RD = 3'd3;
    localparam logic [2:0] SG_RD_END = 3'd4;

    logic [3:0]             phase_reg,   phase_next;
    logic [3:0]             bitcnt_reg,  bitcnt_next;
    logic [DELAY_WIDTH-1:0] dly_reg,     dly_next;
    logic [7:0]             tx_reg,      tx_next;
    logic [7:0]             rx_reg,      rx_next;
    logic                   isrd_reg,    isrd_next;
    logic [7:0]             addr_reg,    addr_next;
    logic [7:0]             wdat_reg,    wdat_next;
    logic [1:0]             err_reg,     err_next;
    logic                   scl_reg,     scl_next;
    logic                   sda_reg,     sda_next;
    logic                   sdaen_reg,   sdaen_next;
    logic [2:0]             stage_reg,   stage_next;
    logic [1:0]             last_reg,    last_next;
    logic                   rvalid_reg,  rvalid_next;
    res_t                   res_reg,     res_next;

    logic [7:0]    tgt_raw;
    logic [CW-1:0] tgt;
    logic [CW-1:0] cnt_plus;
    logic [3:0]    bit_inc;
    logic          done;

    assign pop          = head_valid && (!rvalid_reg || !result_stall);
    assign result_valid = rvalid_reg;
    assign result       = res_reg;

    // delay target of the current phase
    always_comb
    begin
        unique case (phase_reg)
            PH_S_HOLD, PH_W_HOLD, PH_N_HOLD:             tgt_raw = cfg.data_hold_ticks;
            PH_S_LOW:                                    tgt_raw = cfg.start_hold_ticks;
            PH_W_SETUP, PH_N_SETUP, PH_P_SETUP:          tgt_raw = cfg.low_setup_ticks;
            PH_W_HIGH, PH_A_HIGH, PH_R_HIGH, PH_N_HIGH:  tgt_raw = cfg.clock_high_ticks;
            PH_A_LOW, PH_R_LOW:                          tgt_raw = cfg.clock_low_ticks;
            PH_P_HOLD:                                   tgt_raw = cfg.stop_hold_ticks;
            PH_P_FREE:                                   tgt_raw = cfg.bus_free_ticks;
            default:                                     tgt_raw = 8'd1;
        endcase
    end

    always_comb
    begin
        tgt = (tgt_raw == 8'd0) ? CW'(1) : CW'(tgt_raw);
        if (tgt > DLY_MAX)
        begin
            tgt = DLY_MAX;
        end
        cnt_plus = CW'(dly_reg) + CW'(1);
        bit_inc  = bitcnt_reg + 4'd1;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        bitcnt_next = bitcnt_reg;
        dly_next    = dly_reg;
        tx_next     = tx_reg;
        rx_next     = rx_reg;
        isrd_next   = isrd_reg;
        addr_next   = addr_reg;
        wdat_next   = wdat_reg;
        err_next    = err_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        sdaen_next  = sdaen_reg;
        stage_next  = stage_reg;
        last_next   = last_reg;
        done        = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (head.cmd_valid)
            begin
                isrd_next  = head.func;
                addr_next  = head.reg_addr;
                wdat_next  = head.wr_data;
                err_next   = ST_OK;
                rx_next    = 8'd0;
                stage_next = SG_DEV_WR;
                dly_next   = '0;
                scl_next   = 1'b1;
                sdaen_next = 1'b1;
                sda_next   = 1'b1;
                phase_next = PH_S_HOLD;
            end
        end
        else if (head.tick)
        begin
            if (cnt_plus >= tgt)
            begin
                dly_next = '0;
                unique case (phase_reg)
                    PH_S_HOLD:
                    begin
                        scl_next   = 1'b1;
                        sda_next   = 1'b0;
                        phase_next = PH_S_LOW;
                    end
                    PH_S_LOW:
                    begin
                        scl_next    = 1'b0;
                        tx_next     = (stage_reg == SG_DEV_RD)
                                    ? (cfg.device_address | 8'h01)
                                    : (cfg.device_address & 8'hfe);
                        bitcnt_next = 4'd0;
                        sdaen_next  = 1'b1;
                        phase_next  = PH_W_HOLD;
                    end
                    PH_W_HOLD:
                    begin
                        sda_next   = tx_reg[7];
                        phase_next = PH_W_SETUP;
                    end
                    PH_W_SETUP:
                    begin
                        scl_next   = 1'b1;
                        phase_next = PH_W_HIGH;
                    end
                    PH_W_HIGH:
                    begin
                        scl_next    = 1'b0;
                        tx_next     = {tx_reg[6:0], 1'b0};
                        bitcnt_next = bit_inc;
                        if (bit_inc >= 4'd8)
                        begin
                            sdaen_next = 1'b0;
                            sda_next   = 1'b1;
                            phase_next = PH_A_LOW;
                        end
                        else
                        begin
                            phase_next = PH_W_HOLD;
                        end
                    end
                    PH_A_LOW:
                    begin
                        scl_next   = 1'b1;
                        phase_next = PH_A_HIGH;
                    end
                    PH_A_HIGH:
                    begin
                        scl_next = 1'b0;
                        if (head.sda_in)
                        begin
                            // slave NACK: report the failing byte and stop
                            err_next   = (stage_reg == SG_REG)  ? ST_REG_NAK :
                                         (stage_reg == SG_DATA) ? ST_DAT_NAK : ST_DEV_NAK;
                            sdaen_next = 1'b1;
                            sda_next   = 1'b0;
                            phase_next = PH_P_SETUP;
                        end
                        else if (stage_reg == SG_DEV_WR)
                        begin
                            stage_next  = SG_REG;
                            tx_next     = addr_reg;
                            bitcnt_next = 4'd0;
                            sdaen_next  = 1'b1;
                            phase_next  = PH_W_HOLD;
                        end
                        else if (stage_reg == SG_REG)
                        begin
                            if (isrd_reg)
                            begin
                                stage_next = SG_DEV_RD;
                                sdaen_next = 1'b1;
                                sda_next   = 1'b0;
                                phase_next = PH_P_SETUP;
                            end
                            else
                            begin
                                stage_next  = SG_DATA;
                                tx_next     = wdat_reg;
                                bitcnt_next = 4'd0;
                                sdaen_next  = 1'b1;
                                phase_next  = PH_W_HOLD;
                            end
                        end
                        else if (stage_reg == SG_DEV_RD)
                        begin
                            rx_next     = 8'd0;
                            bitcnt_next = 4'd0;
                            sdaen_next  = 1'b0;
                            phase_next  = PH_R_LOW;
                        end
                        else
                        begin
                            sdaen_next = 1'b1;
                            sda_next   = 1'b0;
                            phase_next = PH_P_SETUP;
                        end
                    end
                    PH_R_LOW:
                    begin
                        scl_next   = 1'b1;
                        phase_next = PH_R_HIGH;
                    end
                    PH_R_HIGH:
                    begin
                        rx_next     = {rx_reg[6:0], head.sda_in};
                        scl_next    = 1'b0;
                        bitcnt_next = bit_inc;
                        if (bit_inc >= 4'd8)
                        begin
                            sdaen_next = 1'b1;
                            phase_next = PH_N_HOLD;
                        end
                        else
                        begin
                            phase_next = PH_R_LOW;
                        end
                    end
                    PH_N_HOLD:
                    begin
                        sda_next   = 1'b1;
                        phase_next = PH_N_SETUP;
                    end
                    PH_N_SETUP:
                    begin
                        scl_next   = 1'b1;
                        phase_next = PH_N_HIGH;
                    end
                    PH_N_HIGH:
                    begin
                        scl_next   = 1'b0;
                        stage_next = SG_RD_END;
                        sdaen_next = 1'b1;
                        sda_next   = 1'b0;
                        phase_next = PH_P_SETUP;
                    end
                    PH_P_SETUP:
                    begin
                        scl_next   = 1'b1;
                        phase_next = PH_P_HOLD;
                    end
                    PH_P_HOLD:
                    begin
                        sda_next   = 1'b1;
                        phase_next = PH_P_FREE;
                    end
                    PH_P_FREE:
                    begin
                        if (stage_reg == SG_DEV_RD && err_reg == ST_OK)
                        begin
                            // new start for the read address after the stop
                            sdaen_next = 1'b1;
                            sda_next   = 1'b1;
                            phase_next = PH_S_HOLD;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            sdaen_next = 1'b0;
                            sda_next   = 1'b1;
                            last_next  = err_reg;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        sdaen_next = 1'b0;
                        sda_next   = 1'b1;
                        last_next  = err_reg;
                    end
                endcase
                done = (phase_next == PH_IDLE);
            end
            else
            begin
                dly_next = cnt_plus[DELAY_WIDTH-1:0];
            end
        end
    end

    always_comb
    begin
        res_next.scl       = scl_next;
        res_next.sda_out   = sda_next;
        res_next.sda_drive = sdaen_next;
        res_next.busy_res  = (phase_next != PH_IDLE);
        res_next.done_res  = done;
        res_next.status    = (phase_next == PH_IDLE) ? last_next : ST_OK;
        res_next.rd_data   = (done && isrd_next && err_next == ST_OK) ? rx_next : 8'd0;
        rvalid_next        = pop ? 1'b1 : (rvalid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            bitcnt_reg <= 4'd0;
            dly_reg    <= '0;
            tx_reg     <= 8'd0;
            rx_reg     <= 8'd0;
            isrd_reg   <= 1'b0;
            addr_reg   <= 8'd0;
            wdat_reg   <= 8'd0;
            err_reg    <= ST_OK;
            scl_reg    <= 1'b1;
            sda_reg    <= 1'b1;
            sdaen_reg  <= 1'b0;
            stage_reg  <= SG_DEV_WR;
            last_reg   <= ST_OK;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= rvalid_next;
            if (pop)
            begin
                phase_reg  <= phase_next;
                bitcnt_reg <= bitcnt_next;
                dly_reg    <= dly_next;
                tx_reg     <= tx_next;
                rx_reg     <= rx_next;
                isrd_reg   <= isrd_next;
                addr_reg   <= addr_next;
                wdat_reg   <= wdat_next;
                err_reg    <= err_next;
                scl_reg    <= scl_next;
                sda_reg    <= sda_next;
                sdaen_reg  <= sdaen_next;
                stage_reg  <= stage_next;
                last_reg   <= last_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

endmodule
